### hdl/rc4kc_pkg.sv
// Package with request codes, state encoding and sizes for the RC4 keystream engine.
package rc4kc_pkg;

    localparam int PERM_W     = 8;
    localparam int PERM_DEPTH = 256;
    localparam int LEN_W      = 9;

    typedef enum logic [1:0] {
        REQ_KEY  = 2'd0,
        REQ_INIT = 2'd1,
        REQ_DATA = 2'd2,
        REQ_RSVD = 2'd3
    } t_req;

    typedef enum logic [8:0] {
        ST_FILL   = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_KS_RD  = 9'b000000100,
        ST_KS_J   = 9'b000001000,
        ST_KS_W1  = 9'b000010000,
        ST_KS_W2  = 9'b000100000,
        ST_GEN_J  = 9'b001000000,
        ST_GEN_W1 = 9'b010000000,
        ST_GEN_W2 = 9'b100000000
    } t_state;

endpackage

### hdl/rc4_keystream_cipher.sv
// RC4 keystream engine: key store, permutation memory, key schedule and generation sequencer.
// Data transaction: S[i] read on acceptance, then ST_GEN_J, ST_GEN_W1 and ST_GEN_W2, which waits
//   for a free output and registers the result; the single read port of the permutation memory
//   sets these steps (three dependent reads, two writes). Key byte transaction: stored on acceptance.
// Init transaction (none other taken meanwhile): identity fill, then ST_KS_RD..ST_KS_W2 per swap.
// Reset (synchronous, active low): pointers cleared, key_len 1, then an identity fill.
module rc4_keystream_cipher
    import rc4kc_pkg::*;
#(
    parameter int KEY_MAX = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_req_type,
    input  logic [7:0]       i_key_index,
    input  logic [7:0]       i_key_byte,
    input  logic [7:0]       i_data_byte,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_keystream_byte,
    output logic [7:0]       o_out_byte
);

    localparam int KEY_AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam logic [LEN_W-1:0] KeyMaxLen = LEN_W'(KEY_MAX);

    logic [PERM_W-1:0] r_perm [PERM_DEPTH];
    logic [7:0]        r_key  [KEY_MAX];
    logic [PERM_W-1:0] r_perm_rdata;
    logic [7:0]        r_key_rdata;

    t_state            r_state, n_state;
    logic              r_init_pend, n_init_pend;
    logic [7:0]        r_i, n_i;
    logic [7:0]        r_j, n_j;
    logic [7:0]        r_n, n_n;
    logic              r_out_valid, n_out_valid;
    logic [LEN_W-1:0]  r_key_len;
    logic [7:0]        r_acc, n_acc;
    logic [KEY_AW-1:0] r_pos, n_pos;
    logic [7:0]        r_si, n_si;
    logic [7:0]        r_sj, n_sj;
    logic [7:0]        r_t, n_t;
    logic [7:0]        r_data, n_data;
    logic [7:0]        r_ks, n_ks;
    logic [7:0]        r_out, n_out;

    logic              perm_we, perm_re, key_we, key_re;
    logic [7:0]        perm_waddr, perm_wdata, perm_raddr;
    logic [KEY_AW-1:0] key_waddr, key_raddr;
    logic              in_acc, out_free;
    t_req              req;
    logic [LEN_W-1:0]  eff_len, pos_inc;
    logic [7:0]        acc_nxt, ks;

    always_ff @(posedge i_clk) begin
        if (perm_we) begin
            r_perm[perm_waddr] <= perm_wdata;
        end
        if (perm_re) begin
            r_perm_rdata <= r_perm[perm_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key[key_waddr] <= i_key_byte;
        end
        if (key_re) begin
            r_key_rdata <= r_key[key_raddr];
        end
    end

    assign o_in_ready       = (r_state == ST_IDLE);
    assign in_acc           = i_in_valid && o_in_ready;
    assign req              = t_req'(i_req_type);
    assign out_free         = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_keystream_byte = r_ks;
    assign o_out_byte       = r_out;

    always_comb begin
        priority if (r_key_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_key_len > KeyMaxLen) begin
            eff_len = KeyMaxLen;
        end else begin
            eff_len = r_key_len;
        end
    end

    assign pos_inc = LEN_W'(r_pos) + LEN_W'(1);
    assign acc_nxt = r_acc + r_perm_rdata + r_key_rdata;

    always_comb begin
        priority if (r_t == r_i) begin
            ks = r_sj;
        end else if (r_t == r_j) begin
            ks = r_si;
        end else begin
            ks = r_perm_rdata;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_init_pend = r_init_pend;
        n_i         = r_i;
        n_j         = r_j;
        n_n         = r_n;
        n_acc       = r_acc;
        n_pos       = r_pos;
        n_si        = r_si;
        n_sj        = r_sj;
        n_t         = r_t;
        n_data      = r_data;
        n_ks        = r_ks;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        perm_we     = 1'b0;
        perm_waddr  = r_n;
        perm_wdata  = r_n;
        perm_re     = 1'b0;
        perm_raddr  = r_n;
        key_we      = 1'b0;
        key_waddr   = i_key_index[KEY_AW-1:0];
        key_re      = 1'b0;
        key_raddr   = r_pos;

        unique case (r_state)
            ST_FILL: begin
                perm_we = 1'b1;
                n_n     = r_n + 8'd1;
                if (r_n == 8'hFF) begin
                    n_init_pend = 1'b0;
                    n_acc       = '0;
                    n_pos       = '0;
                    n_state     = r_init_pend ? ST_KS_RD : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (req)
                        REQ_KEY: begin
                            key_we = (LEN_W'(i_key_index) < KeyMaxLen);
                        end
                        REQ_INIT: begin
                            n_i         = '0;
                            n_j         = '0;
                            n_n         = '0;
                            n_init_pend = 1'b1;
                            n_state     = ST_FILL;
                        end
                        REQ_DATA: begin
                            n_i        = r_i + 8'd1;
                            perm_re    = 1'b1;
                            perm_raddr = r_i + 8'd1;
                            n_data     = i_data_byte;
                            n_state    = ST_GEN_J;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_KS_RD: begin
                perm_re = 1'b1;
                key_re  = 1'b1;
                n_state = ST_KS_J;
            end
            ST_KS_J: begin
                n_acc      = acc_nxt;
                n_si       = r_perm_rdata;
                perm_re    = 1'b1;
                perm_raddr = acc_nxt;
                n_state    = ST_KS_W1;
            end
            ST_KS_W1: begin
                perm_we    = 1'b1;
                perm_wdata = r_perm_rdata;
                n_state    = ST_KS_W2;
            end
            ST_KS_W2: begin
                perm_we    = 1'b1;
                perm_waddr = r_acc;
                perm_wdata = r_si;
                n_n        = r_n + 8'd1;
                n_pos      = (pos_inc >= eff_len) ? '0 : KEY_AW'(pos_inc);
                n_state    = (r_n == 8'hFF) ? ST_IDLE : ST_KS_RD;
            end
            ST_GEN_J: begin
                n_j        = r_j + r_perm_rdata;
                n_si       = r_perm_rdata;
                perm_re    = 1'b1;
                perm_raddr = r_j + r_perm_rdata;
                n_state    = ST_GEN_W1;
            end
            ST_GEN_W1: begin
                perm_we    = 1'b1;
                perm_waddr = r_i;
                perm_wdata = r_perm_rdata;
                n_sj       = r_perm_rdata;
                n_t        = r_si + r_perm_rdata;
                perm_re    = 1'b1;
                perm_raddr = r_si + r_perm_rdata;
                n_state    = ST_GEN_W2;
            end
            ST_GEN_W2: begin
                if (out_free) begin
                    perm_we     = 1'b1;
                    perm_waddr  = r_j;
                    perm_wdata  = r_si;
                    n_out_valid = 1'b1;
                    n_ks        = ks;
                    n_out       = r_data ^ ks;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_init_pend <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
            r_key_len   <= LEN_W'(1);
        end else begin
            r_state     <= n_state;
            r_init_pend <= n_init_pend;
            r_i         <= n_i;
            r_j         <= n_j;
            r_n         <= n_n;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_key_len <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_pos  <= n_pos;
        r_si   <= n_si;
        r_sj   <= n_sj;
        r_t    <= n_t;
        r_data <= n_data;
        r_ks   <= n_ks;
        r_out  <= n_out;
    end

    a_result_from_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_GEN_W2))
        else $error("result raised outside the final generation step");

    a_init_starts_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type == REQ_INIT) |=> (r_state == ST_FILL && r_n == 8'd0 && r_init_pend))
        else $error("init transaction did not start the identity fill");

    a_data_advances_i: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type == REQ_DATA) |=> (r_i == $past(r_i) + 8'd1))
        else $error("data transaction did not advance index i");

    a_stall_holds_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GEN_W2 && o_out_valid && !i_out_ready) |=> (r_state == ST_GEN_W2))
        else $error("result overwrote a pending transaction");

endmodule

### tb/testbench.sv
// Self-checking testbench for the RC4 keystream engine with its own RC4 predictor.
`timescale 1ns / 1ps

module testbench;
    import rc4kc_pkg::*;

    localparam int DRAIN_CYCLES = 1400;
    localparam int MAX_SHOWN    = 10;

    typedef struct {
        t_req       req;
        logic [7:0] key_index;
        logic [7:0] key_byte;
        logic [7:0] data_byte;
    } t_rc4_req;

    typedef struct {
        logic [7:0] ks;
        logic [7:0] out_b;
    } t_ks_pair;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [LEN_W-1:0] i_cfg_wdata = '0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    logic [1:0]       i_req_type  = 2'd0;
    logic [7:0]       i_key_index = 8'd0;
    logic [7:0]       i_key_byte  = 8'd0;
    logic [7:0]       i_data_byte = 8'd0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [7:0]       o_keystream_byte;
    logic [7:0]       o_out_byte;

    rc4_keystream_cipher DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_key_index      (i_key_index),
        .i_key_byte       (i_key_byte),
        .i_data_byte      (i_data_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_keystream_byte (o_keystream_byte),
        .o_out_byte       (o_out_byte)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [7:0] sbox [256];
    logic [7:0] keybuf [256];
    logic [7:0] ptr_i = 8'd0;
    logic [7:0] ptr_j = 8'd0;
    logic [8:0] sched_len = 9'd1;

    // stimulus bookkeeping
    t_rc4_req   pending_q [$];
    t_ks_pair   keystream_q [$];
    logic       key_set [256];
    logic [8:0] gen_len = 9'd1;
    int         push_count   = 0;
    int         accept_count = 0;
    int         phase_data   = 0;
    int         error_count  = 0;
    int         result_count = 0;

    function automatic int clamp_len(logic [8:0] v);
        if (v == 9'd0) return 1;
        if (v > 9'd256) return 256;
        return int'(v);
    endfunction

    function automatic void rc4_apply(t_rc4_req it);
        logic [7:0] acc;
        logic [7:0] t;
        logic [7:0] a;
        t_ks_pair   res;
        int         len;
        int         pos;
        int         n;
        case (it.req)
            REQ_KEY: begin
                keybuf[it.key_index] = it.key_byte;
            end
            REQ_INIT: begin
                len = clamp_len(sched_len);
                pos = 0;
                acc = 8'd0;
                for (n = 0; n < 256; n++) sbox[n] = n[7:0];
                for (n = 0; n < 256; n++) begin
                    acc = acc + sbox[n] + keybuf[pos];
                    t = sbox[n];
                    sbox[n] = sbox[acc];
                    sbox[acc] = t;
                    pos++;
                    if (pos >= len) pos = 0;
                end
                ptr_i = 8'd0;
                ptr_j = 8'd0;
            end
            REQ_DATA: begin
                ptr_i = ptr_i + 8'd1;
                ptr_j = ptr_j + sbox[ptr_i];
                t = sbox[ptr_i];
                sbox[ptr_i] = sbox[ptr_j];
                sbox[ptr_j] = t;
                a = sbox[ptr_i] + sbox[ptr_j];
                res.ks = sbox[a];
                res.out_b = it.data_byte ^ sbox[a];
                keystream_q.push_back(res);
            end
            default: begin
            end
        endcase
    endfunction

    task automatic push_req(t_req req, logic [7:0] kidx, logic [7:0] kbyte, logic [7:0] data);
        t_rc4_req it;
        it.req = req;
        it.key_index = kidx;
        it.key_byte = kbyte;
        it.data_byte = data;
        pending_q.push_back(it);
        push_count++;
        if (req == REQ_KEY) key_set[kidx] = 1'b1;
        if (req == REQ_DATA) phase_data++;
    endtask

    task automatic push_init();
        int n;
        for (n = 0; n < clamp_len(gen_len); n++) begin
            if (!key_set[n]) push_req(REQ_KEY, n[7:0], 8'($urandom), 8'($urandom));
        end
        push_req(REQ_INIT, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic push_session();
        int n_keys;
        int n_data;
        int k;
        int r;
        n_keys = $urandom_range(0, 4);
        for (k = 0; k < n_keys; k++) begin
            push_req(REQ_KEY, 8'($urandom_range(0, clamp_len(gen_len) - 1)),
                     8'($urandom), 8'($urandom));
        end
        if ($urandom_range(0, 99) >= 15) push_init();
        n_data = $urandom_range(4, 20);
        for (k = 0; k < n_data; k++) begin
            r = $urandom_range(0, 99);
            if (r < 6)
                push_req(REQ_RSVD, 8'($urandom), 8'($urandom), 8'($urandom));
            else if (r < 10)
                push_req(REQ_KEY, 8'($urandom), 8'($urandom), 8'($urandom));
            else if (r < 12)
                push_init();
            else
                push_req(REQ_DATA, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic wait_idle();
        while (accept_count != push_count || keystream_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_key_len(logic [8:0] v);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        sched_len = v;
        gen_len = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // driver: bursts of transactions with random gaps
    t_rc4_req offer;
    int       gap_left   = 0;
    int       burst_left = 1;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                rc4_apply(offer);
                accept_count++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    offer = pending_q.pop_front();
                    i_req_type  <= offer.req;
                    i_key_index <= offer.key_index;
                    i_key_byte  <= offer.key_byte;
                    i_data_byte <= offer.data_byte;
                    i_in_valid  <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check results, stall on its own pattern
    t_ks_pair   want;
    int         hold_left  = 0;
    logic       long_done  = 1'b0;
    int         stall_mode = 0;
    logic [5:0] mode_cnt   = 6'd0;
    logic       rdy;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                result_count++;
                if (keystream_q.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_SHOWN)
                        $display("unexpected result: ks=%02h out=%02h",
                                 o_keystream_byte, o_out_byte);
                end else begin
                    want = keystream_q.pop_front();
                    if (want.ks !== o_keystream_byte || want.out_b !== o_out_byte) begin
                        error_count++;
                        if (error_count <= MAX_SHOWN)
                            $display("mismatch #%0d: expected ks=%02h out=%02h, %s",
                                     result_count, want.ks, want.out_b,
                                     $sformatf("got ks=%02h out=%02h",
                                               o_keystream_byte, o_out_byte));
                    end
                end
            end
            mode_cnt = mode_cnt + 6'd1;
            if (mode_cnt == 6'd0) stall_mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!long_done && result_count >= 40) begin
                long_done = 1'b1;
                hold_left = 300;
                rdy = 1'b0;
            end else if ($urandom_range(0, 999) == 0) begin
                hold_left = $urandom_range(50, 200);
                rdy = 1'b0;
            end else begin
                case (stall_mode)
                    0: rdy = 1'b1;
                    1: rdy = 1'($urandom_range(0, 1));
                    2: rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = (mode_cnt[2:0] != 3'd0);
                endcase
            end
            i_out_ready <= rdy;
        end
    end

    initial begin
        #10_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        logic [8:0] lens [10];
        int p;
        int n;
        for (n = 0; n < 256; n++) begin
            sbox[n] = n[7:0];
            keybuf[n] = 8'd0;
            key_set[n] = 1'b0;
        end
        lens = '{9'd0, 9'd2, 9'd16, 9'd511, 9'd255, 9'd257, 9'd5, 9'd256, 9'd1, 9'd0};
        lens[9] = 9'($urandom_range(1, 255));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity permutation before any key schedule
        push_req(REQ_DATA, 8'h00, 8'h00, 8'h00);
        push_req(REQ_DATA, 8'hFF, 8'hFF, 8'hFF);
        push_req(REQ_RSVD, 8'h00, 8'hAA, 8'h55);
        push_req(REQ_KEY,  8'h00, 8'hFF, 8'h00);
        push_req(REQ_KEY,  8'hFF, 8'h00, 8'hFF);
        push_req(REQ_INIT, 8'h00, 8'h00, 8'h00);
        push_req(REQ_DATA, 8'h00, 8'h00, 8'h00);
        push_req(REQ_DATA, 8'h00, 8'h00, 8'hFF);
        push_req(REQ_DATA, 8'hFF, 8'hFF, 8'hA5);
        push_req(REQ_RSVD, 8'hFF, 8'hFF, 8'hFF);
        push_req(REQ_DATA, 8'h00, 8'h00, 8'h5A);
        push_req(REQ_KEY,  8'h00, 8'h00, 8'h00);
        push_req(REQ_INIT, 8'hFF, 8'hFF, 8'hFF);
        push_req(REQ_DATA, 8'h00, 8'h00, 8'h01);
        push_req(REQ_DATA, 8'h00, 8'h00, 8'h80);
        push_req(REQ_KEY,  8'hFF, 8'hFF, 8'h00);
        push_req(REQ_DATA, 8'h00, 8'h00, 8'h7F);
        push_req(REQ_INIT, 8'h00, 8'h00, 8'h00);
        push_req(REQ_DATA, 8'h00, 8'h00, 8'hFE);

        for (p = 0; p < 10; p++) begin
            write_key_len(lens[p]);
            phase_data = 0;
            while (phase_data < 4) push_session();
        end

        while (accept_count != push_count || keystream_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && keystream_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
